[rtl/core/acd_pkg.sv]
// Shared types, constants and helper functions for the ArtDmx control channel decoder.
package acd_pkg;

	// Number of DMX slots that drive the control state.
	localparam int unsigned CONTROL_SLOTS = 8;

	// Header layout and limits.
	localparam logic [9:0]  HDR_LEN     = 10'd18;
	localparam logic [9:0]  COUNT_MAX   = 10'd1023;
	localparam logic [9:0]  ID_LEN      = 10'd8;
	localparam logic [9:0]  POS_OP_LO   = 10'd8;
	localparam logic [9:0]  POS_OP_HI   = 10'd9;
	localparam logic [9:0]  POS_VER_HI  = 10'd10;
	localparam logic [9:0]  POS_VER_LO  = 10'd11;
	localparam logic [9:0]  POS_SUBUNI  = 10'd14;
	localparam logic [9:0]  POS_NET     = 10'd15;
	localparam logic [9:0]  POS_LEN_HI  = 10'd16;
	localparam logic [9:0]  POS_LEN_LO  = 10'd17;
	localparam logic [15:0] OP_DMX      = 16'h5000;
	localparam logic [15:0] MIN_VERSION = 16'd14;
	localparam logic [15:0] MIN_SLOTS   = 16'd2;
	localparam logic [15:0] MAX_SLOTS   = 16'd512;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_ID    = 3'd2;
	localparam logic [2:0] ST_OPCODE    = 3'd3;
	localparam logic [2:0] ST_VERSION   = 3'd4;
	localparam logic [2:0] ST_SLOTS     = 3'd5;
	localparam logic [2:0] ST_TRUNCATED = 3'd6;
	localparam logic [2:0] ST_UNIVERSE  = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] REG_UNIVERSE_FILTER = 3'd0;
	localparam logic [2:0] REG_START_SLOT      = 3'd1;
	localparam logic [2:0] REG_FREQ_MIN        = 3'd2;
	localparam logic [2:0] REG_FREQ_MAX        = 3'd3;
	localparam logic [2:0] REG_AMP_MAX         = 3'd4;
	localparam logic [2:0] REG_MORPH_MAX       = 3'd5;

	// Configuration reset values.
	localparam logic [14:0] RST_UNIVERSE_FILTER = 15'd0;
	localparam logic [9:0]  RST_START_SLOT      = 10'd1;
	localparam logic [7:0]  RST_FREQ_MIN        = 8'd1;
	localparam logic [7:0]  RST_FREQ_MAX        = 8'd8;
	localparam logic [14:0] RST_AMP_MAX         = 15'd1024;
	localparam logic [15:0] RST_MORPH_MAX       = 16'd1608;

	// Held control state reset values.
	localparam logic [7:0]  RST_HELD_FREQ_X    = 8'd3;
	localparam logic [7:0]  RST_HELD_FREQ_Y    = 8'd2;
	localparam logic [15:0] RST_HELD_INTENSITY = 16'd16384;
	localparam logic [15:0] RST_HELD_MORPH     = 16'd256;

	// Fixed scale factors and their upper bounds.
	localparam logic [23:0] HUE_SCALE   = 24'd46080;
	localparam logic [23:0] PHASE_SCALE = 24'd51472;
	localparam logic [15:0] HUE_MAX     = 16'd46080;
	localparam logic [15:0] PHASE_MAX   = 16'd51472;

	// Reciprocal of 255 scaled by 2^32, rounded up; exact for dividends below 2^24.
	localparam logic [48:0] RECIP_255 = 49'd16843010;

	typedef logic [CONTROL_SLOTS-1:0][7:0] slot_vec_t;

	typedef struct packed {
		logic [14:0] universe_filter;
		logic [9:0]  start_slot;
		logic [7:0]  freq_min;
		logic [7:0]  freq_max;
		logic [14:0] amp_max;
		logic [15:0] morph_max;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] universe;
		slot_vec_t   slot;
	} frame_t;

	// Expected identifier byte at each header position.
	function automatic logic [7:0] id_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'h41;
			3'd1:    b = 8'h72;
			3'd2:    b = 8'h74;
			3'd3:    b = 8'h2D;
			3'd4:    b = 8'h4E;
			3'd5:    b = 8'h65;
			3'd6:    b = 8'h74;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Truncating division by 255 through a reciprocal multiply.
	function automatic logic [15:0] div255(input logic [23:0] x);
		logic [48:0] p;
		p = {25'b0, x} * RECIP_255;
		return p[47:32];
	endfunction

endpackage

[rtl/core/acd_parser.sv]
// Header and slot capture for incoming payload bytes, with the checked frame register.
module acd_parser #(
	parameter logic [15:0] MAX_SLOTS = acd_pkg::MAX_SLOTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  acd_pkg::cfg_t   cfg,
	output logic            frame_valid_s1,
	output acd_pkg::frame_t frame_s1,
	input  logic            frame_ready
);

	logic [9:0]         count_q, count_d;
	logic               id_q, id_d;
	logic [15:0]        op_q, op_d;
	logic [15:0]        ver_q, ver_d;
	logic [15:0]        slots_q, slots_d;
	logic [14:0]        addr_q, addr_d;
	acd_pkg::slot_vec_t cap_q, cap_d;
	logic [9:0]         idx;
	logic [9:0]         first;
	logic [9:0]         off;
	logic [16:0]        need_len;
	logic [2:0]         status_d;
	logic               accept;

	assign in_ready = !frame_valid_s1 || frame_ready;
	assign accept   = in_valid && in_ready;

	// Field capture for the byte at the current position.
	always_comb begin
		count_d = (count_q == acd_pkg::COUNT_MAX) ? count_q : count_q + 10'd1;
		id_d    = id_q;
		op_d    = op_q;
		ver_d   = ver_q;
		slots_d = slots_q;
		addr_d  = addr_q;
		cap_d   = cap_q;
		idx     = count_q - acd_pkg::HDR_LEN;
		first   = (cfg.start_slot == 10'd0) ? 10'd0 : cfg.start_slot - 10'd1;
		off     = idx - first;
		if (count_q < acd_pkg::ID_LEN) begin
			if (data_byte != acd_pkg::id_byte(count_q[2:0])) begin
				id_d = 1'b0;
			end
		end else begin
			case (count_q)
				acd_pkg::POS_OP_LO:  op_d[7:0]    = data_byte;
				acd_pkg::POS_OP_HI:  op_d[15:8]   = data_byte;
				acd_pkg::POS_VER_HI: ver_d[15:8]  = data_byte;
				acd_pkg::POS_VER_LO: ver_d[7:0]   = data_byte;
				acd_pkg::POS_SUBUNI: addr_d[7:0]  = data_byte;
				acd_pkg::POS_NET:    addr_d[14:8] = data_byte[6:0];
				acd_pkg::POS_LEN_HI: slots_d[15:8] = data_byte;
				acd_pkg::POS_LEN_LO: slots_d[7:0]  = data_byte;
				default: begin
					// Slot bytes inside the control window and inside the frame.
					if (count_q >= acd_pkg::HDR_LEN && count_q < acd_pkg::COUNT_MAX &&
							idx >= first && off < 10'(acd_pkg::CONTROL_SLOTS) &&
							{6'b0, idx} < slots_q) begin
						cap_d[off[2:0]] = data_byte;
					end
				end
			endcase
		end
	end

	// Datagram checks in priority order, on the state including this byte.
	always_comb begin
		need_len = {7'b0, acd_pkg::HDR_LEN} + {1'b0, slots_d};
		if (count_d < acd_pkg::HDR_LEN) begin
			status_d = acd_pkg::ST_SHORT;
		end else if (!id_d) begin
			status_d = acd_pkg::ST_BAD_ID;
		end else if (op_d != acd_pkg::OP_DMX) begin
			status_d = acd_pkg::ST_OPCODE;
		end else if (ver_d < acd_pkg::MIN_VERSION) begin
			status_d = acd_pkg::ST_VERSION;
		end else if (slots_d < acd_pkg::MIN_SLOTS || slots_d > MAX_SLOTS) begin
			status_d = acd_pkg::ST_SLOTS;
		end else if ({7'b0, count_d} < need_len) begin
			status_d = acd_pkg::ST_TRUNCATED;
		end else if (addr_d != cfg.universe_filter) begin
			status_d = acd_pkg::ST_UNIVERSE;
		end else begin
			status_d = acd_pkg::ST_OK;
		end
	end

	// Capture state; the final byte returns it to the start of a datagram.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			id_q    <= 1'b1;
			op_q    <= '0;
			ver_q   <= '0;
			slots_q <= '0;
			addr_q  <= '0;
			cap_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				id_q    <= 1'b1;
				op_q    <= '0;
				ver_q   <= '0;
				slots_q <= '0;
				addr_q  <= '0;
				cap_q   <= '0;
			end else begin
				count_q <= count_d;
				id_q    <= id_d;
				op_q    <= op_d;
				ver_q   <= ver_d;
				slots_q <= slots_d;
				addr_q  <= addr_d;
				cap_q   <= cap_d;
			end
		end
	end

	// Frame register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_ready) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	// Frame register payload.
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			frame_s1.status   <= status_d;
			frame_s1.universe <= (count_d < acd_pkg::HDR_LEN) ? 15'd0 : addr_d;
			frame_s1.slot     <= cap_d;
		end
	end

endmodule

[rtl/core/acd_scaler.sv]
// Slot scaling into the held control state and the result register.
module acd_scaler (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            frame_valid_s1,
	input  acd_pkg::frame_t frame_s1,
	output logic            frame_ready,
	input  acd_pkg::cfg_t   cfg,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [14:0]     packet_universe,
	output logic            mode,
	output logic [7:0]      freq_x,
	output logic [7:0]      freq_y,
	output logic [14:0]     amplitude,
	output logic [15:0]     hue,
	output logic [15:0]     intensity,
	output logic [15:0]     morph_speed,
	output logic [15:0]     phase_offset
);

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] universe;
		logic        mode;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [22:0] amp;
		logic [23:0] hue;
		logic [15:0] intensity;
		logic [23:0] morph;
		logic [23:0] phase;
	} prod_t;

	logic        valid_s2;
	prod_t       prod_s2;
	prod_t       prod_d;
	logic [7:0]  span;
	logic        out_load;
	logic [15:0] quo_fx, quo_fy, quo_amp, quo_hue, quo_morph, quo_phase;

	assign out_load    = valid_s2 && (!out_valid || out_ready);
	assign frame_ready = !valid_s2 || out_load;

	// Products of the slots with their scales; mode is the top bit of slot 0 and intensity repeats slot 5.
	always_comb begin
		span             = (cfg.freq_max >= cfg.freq_min) ? cfg.freq_max - cfg.freq_min : 8'd0;
		prod_d.status    = frame_s1.status;
		prod_d.universe  = frame_s1.universe;
		prod_d.mode      = frame_s1.slot[0][7];
		prod_d.fx        = {8'b0, frame_s1.slot[1]} * {8'b0, span};
		prod_d.fy        = {8'b0, frame_s1.slot[2]} * {8'b0, span};
		prod_d.amp       = {15'b0, frame_s1.slot[3]} * {8'b0, cfg.amp_max};
		prod_d.hue       = {16'b0, frame_s1.slot[4]} * acd_pkg::HUE_SCALE;
		prod_d.intensity = {frame_s1.slot[5], frame_s1.slot[5]};
		prod_d.morph     = {16'b0, frame_s1.slot[6]} * {8'b0, cfg.morph_max};
		prod_d.phase     = {16'b0, frame_s1.slot[7]} * acd_pkg::PHASE_SCALE;
	end

	// Quotients by 255 of the registered products.
	always_comb begin
		quo_fx    = acd_pkg::div255({8'b0, prod_s2.fx});
		quo_fy    = acd_pkg::div255({8'b0, prod_s2.fy});
		quo_amp   = acd_pkg::div255({1'b0, prod_s2.amp});
		quo_hue   = acd_pkg::div255(prod_s2.hue);
		quo_morph = acd_pkg::div255(prod_s2.morph);
		quo_phase = acd_pkg::div255(prod_s2.phase);
	end

	// Product stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (frame_ready) begin
			valid_s2 <= frame_valid_s1;
		end
	end

	// Product stage payload.
	always_ff @(posedge clk) begin
		if (frame_valid_s1 && frame_ready) begin
			prod_s2 <= prod_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result status and universe.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status          <= prod_s2.status;
			packet_universe <= prod_s2.universe;
		end
	end

	// Held control state, updated only by an accepted packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode         <= 1'b0;
			freq_x       <= acd_pkg::RST_HELD_FREQ_X;
			freq_y       <= acd_pkg::RST_HELD_FREQ_Y;
			amplitude    <= acd_pkg::RST_AMP_MAX;
			hue          <= '0;
			intensity    <= acd_pkg::RST_HELD_INTENSITY;
			morph_speed  <= acd_pkg::RST_HELD_MORPH;
			phase_offset <= '0;
		end else if (out_load && prod_s2.status == acd_pkg::ST_OK) begin
			mode         <= prod_s2.mode;
			freq_x       <= cfg.freq_min + quo_fx[7:0];
			freq_y       <= cfg.freq_min + quo_fy[7:0];
			amplitude    <= quo_amp[14:0];
			hue          <= quo_hue;
			intensity    <= prod_s2.intensity;
			morph_speed  <= quo_morph;
			phase_offset <= quo_phase;
		end
	end

endmodule

[rtl/core/artdmx_control_channel_decoder.sv]
// ArtDmx control channel decoder: an Art-Net DMX packet parser driving held control state.
//
// Payload bytes enter one per cycle on the input channel, last_byte marking the end of a
// datagram; each byte needs only field capture, so a byte is taken every cycle unless
// the frame, product and result registers all hold results and the output is stalled,
// in which case the input waits until the result is taken. Each final byte yields one
// result through three registers (checked frame, slot products, result register),
// carrying the status of the first failed check, the packet's port address and the
// held control state after the datagram. Bytes that are not final produce no result.
// An accepted packet rescales eight DMX slots, starting at the configured start slot,
// into mode, frequencies, amplitude, hue, intensity, morph rate and phase; a rejected
// one leaves them as they were. The block is usable right after reset.
module artdmx_control_channel_decoder #(
	parameter logic [15:0] MAX_SLOTS = acd_pkg::MAX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [14:0] packet_universe,
	output logic        mode,
	output logic [7:0]  freq_x,
	output logic [7:0]  freq_y,
	output logic [14:0] amplitude,
	output logic [15:0] hue,
	output logic [15:0] intensity,
	output logic [15:0] morph_speed,
	output logic [15:0] phase_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	acd_pkg::cfg_t   cfg_q;
	logic            frame_valid_s1;
	acd_pkg::frame_t frame_s1;
	logic            frame_ready;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.universe_filter <= acd_pkg::RST_UNIVERSE_FILTER;
			cfg_q.start_slot      <= acd_pkg::RST_START_SLOT;
			cfg_q.freq_min        <= acd_pkg::RST_FREQ_MIN;
			cfg_q.freq_max        <= acd_pkg::RST_FREQ_MAX;
			cfg_q.amp_max         <= acd_pkg::RST_AMP_MAX;
			cfg_q.morph_max       <= acd_pkg::RST_MORPH_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acd_pkg::REG_UNIVERSE_FILTER: cfg_q.universe_filter <= cfg_data[14:0];
				acd_pkg::REG_START_SLOT:      cfg_q.start_slot      <= cfg_data[9:0];
				acd_pkg::REG_FREQ_MIN:        cfg_q.freq_min        <= cfg_data[7:0];
				acd_pkg::REG_FREQ_MAX:        cfg_q.freq_max        <= cfg_data[7:0];
				acd_pkg::REG_AMP_MAX:         cfg_q.amp_max         <= cfg_data[14:0];
				acd_pkg::REG_MORPH_MAX:       cfg_q.morph_max       <= cfg_data;
				default: ;
			endcase
		end
	end

	acd_parser #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.cfg            (cfg_q),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.frame_ready    (frame_ready)
	);

	acd_scaler u_scaler (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_valid_s1  (frame_valid_s1),
		.frame_s1        (frame_s1),
		.frame_ready     (frame_ready),
		.cfg             (cfg_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.packet_universe (packet_universe),
		.mode            (mode),
		.freq_x          (freq_x),
		.freq_y          (freq_y),
		.amplitude       (amplitude),
		.hue             (hue),
		.intensity       (intensity),
		.morph_speed     (morph_speed),
		.phase_offset    (phase_offset)
	);

	// A short datagram never reports a port address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == acd_pkg::ST_SHORT |-> packet_universe == 15'd0)
		else $error("short datagram reported a nonzero universe");

	// A newly shown rejected packet leaves the held state untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && status != acd_pkg::ST_OK |->
			$stable(hue) && $stable(amplitude) && $stable(morph_speed) && $stable(freq_x))
		else $error("rejected packet changed the held state");

	// Fixed scales keep hue and phase inside their full ranges.
	assert property (@(posedge clk) disable iff (!arst_n)
		hue <= acd_pkg::HUE_MAX && phase_offset <= acd_pkg::PHASE_MAX)
		else $error("hue or phase beyond full scale");

endmodule

[tb/artdmx_control_channel_decoder_test.sv]
// Self-checking testbench for the ArtDmx control channel decoder.
`timescale 1ns / 100ps

module artdmx_control_channel_decoder_test;

	// Register index with no register behind it; a write there changes nothing.
	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam logic [63:0] ART_ID = {"Art-Net", 8'h00};
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic        mode;
		logic [7:0]  freq_x;
		logic [7:0]  freq_y;
		logic [14:0] amplitude;
		logic [15:0] hue;
		logic [15:0] intensity;
		logic [15:0] morph;
		logic [15:0] phase;
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] universe;
		ctrl_state_t ctl;
	} dmx_result_t;

	// One payload byte to send, or a marker that makes the sender wait for all results.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pause;
	} payload_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [14:0] packet_universe;
	logic        mode;
	logic [7:0]  freq_x;
	logic [7:0]  freq_y;
	logic [14:0] amplitude;
	logic [15:0] hue;
	logic [15:0] intensity;
	logic [15:0] morph_speed;
	logic [15:0] phase_offset;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;

	payload_byte_t tx_bytes[$];
	dmx_result_t   pending_results[$];
	bit            byte_taken = 1'b0;
	bit            failed = 1'b0;
	int unsigned   snd_idle_pct = 0;
	int unsigned   rcv_stall_pct = 0;
	bit            rcv_hold_req = 1'b0;
	int unsigned   rcv_hold_left = 0;

	// Decoder state mirrored by the testbench.
	acd_pkg::cfg_t cfg = '{acd_pkg::RST_UNIVERSE_FILTER, acd_pkg::RST_START_SLOT,
		acd_pkg::RST_FREQ_MIN, acd_pkg::RST_FREQ_MAX, acd_pkg::RST_AMP_MAX,
		acd_pkg::RST_MORPH_MAX};
	int unsigned byte_pos = 0;
	bit          id_ok = 1'b1;
	logic [15:0] op_word = 16'd0;
	logic [15:0] ver_word = 16'd0;
	logic [15:0] frame_slots = 16'd0;
	logic [14:0] port_addr = 15'd0;
	logic [7:0]  cap_slot [acd_pkg::CONTROL_SLOTS] = '{default: 8'd0};
	ctrl_state_t held = '{1'b0, acd_pkg::RST_HELD_FREQ_X, acd_pkg::RST_HELD_FREQ_Y,
		acd_pkg::RST_AMP_MAX, 16'd0, acd_pkg::RST_HELD_INTENSITY, acd_pkg::RST_HELD_MORPH,
		16'd0};

	artdmx_control_channel_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.packet_universe(packet_universe),
		.mode(mode),
		.freq_x(freq_x),
		.freq_y(freq_y),
		.amplitude(amplitude),
		.hue(hue),
		.intensity(intensity),
		.morph_speed(morph_speed),
		.phase_offset(phase_offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned scale(input int unsigned s, input int unsigned full);
		return s * full / 255;
	endfunction

	// Updates the mirrored state with one payload byte; a final byte yields a result.
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		int unsigned pos, idx, first, span;
		dmx_result_t r;
		pos = byte_pos;
		if (pos < 8) begin
			if (b != ART_ID[63 - 8*pos -: 8]) id_ok = 1'b0;
		end else if (pos == acd_pkg::POS_OP_LO) begin
			op_word[7:0] = b;
		end else if (pos == acd_pkg::POS_OP_HI) begin
			op_word[15:8] = b;
		end else if (pos == acd_pkg::POS_VER_HI) begin
			ver_word[15:8] = b;
		end else if (pos == acd_pkg::POS_VER_LO) begin
			ver_word[7:0] = b;
		end else if (pos == acd_pkg::POS_SUBUNI) begin
			port_addr[7:0] = b;
		end else if (pos == acd_pkg::POS_NET) begin
			port_addr[14:8] = b[6:0];
		end else if (pos == acd_pkg::POS_LEN_HI) begin
			frame_slots[15:8] = b;
		end else if (pos == acd_pkg::POS_LEN_LO) begin
			frame_slots[7:0] = b;
		end else if (pos >= acd_pkg::HDR_LEN && pos < acd_pkg::COUNT_MAX) begin
			// Slots are taken from the start slot on, and only inside the frame.
			idx = pos - acd_pkg::HDR_LEN;
			first = (cfg.start_slot == 10'd0) ? 0 : cfg.start_slot - 1;
			if (idx >= first && idx - first < acd_pkg::CONTROL_SLOTS && idx < frame_slots)
				cap_slot[idx - first] = b;
		end
		if (byte_pos < acd_pkg::COUNT_MAX) byte_pos++;
		if (fin) begin
			r.universe = (byte_pos < acd_pkg::HDR_LEN) ? 15'd0 : port_addr;
			if (byte_pos < acd_pkg::HDR_LEN) r.status = acd_pkg::ST_SHORT;
			else if (!id_ok) r.status = acd_pkg::ST_BAD_ID;
			else if (op_word != acd_pkg::OP_DMX) r.status = acd_pkg::ST_OPCODE;
			else if (ver_word < acd_pkg::MIN_VERSION) r.status = acd_pkg::ST_VERSION;
			else if (frame_slots < acd_pkg::MIN_SLOTS || frame_slots > acd_pkg::MAX_SLOTS)
				r.status = acd_pkg::ST_SLOTS;
			else if (byte_pos < acd_pkg::HDR_LEN + frame_slots)
				r.status = acd_pkg::ST_TRUNCATED;
			else if (port_addr != cfg.universe_filter) r.status = acd_pkg::ST_UNIVERSE;
			else r.status = acd_pkg::ST_OK;
			// An accepted packet rescales the captured slots into the held state.
			if (r.status == acd_pkg::ST_OK) begin
				span = (cfg.freq_max >= cfg.freq_min) ? cfg.freq_max - cfg.freq_min : 0;
				held.mode = cap_slot[0][7];
				held.freq_x = 8'(cfg.freq_min + scale(cap_slot[1], span));
				held.freq_y = 8'(cfg.freq_min + scale(cap_slot[2], span));
				held.amplitude = 15'(scale(cap_slot[3], cfg.amp_max));
				held.hue = 16'(scale(cap_slot[4], acd_pkg::HUE_SCALE));
				held.intensity = 16'(cap_slot[5] * 257);
				held.morph = 16'(scale(cap_slot[6], cfg.morph_max));
				held.phase = 16'(scale(cap_slot[7], acd_pkg::PHASE_SCALE));
			end
			r.ctl = held;
			pending_results.push_back(r);
			byte_pos = 0;
			id_ok = 1'b1;
			op_word = 16'd0;
			ver_word = 16'd0;
			frame_slots = 16'd0;
			port_addr = 15'd0;
			cap_slot = '{default: 8'd0};
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic logic [7:0] pick_slot(input int fill);
		if (fill >= 0) return 8'(fill);
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Queues one datagram: header, body of slot bytes, optionally cut short.
	task automatic push_dgram(input logic [15:0] op, input logic [15:0] ver,
			input logic [14:0] uni, input logic [15:0] count, input int unsigned body,
			input int unsigned cut, input bit bad_id, input int fill);
		logic [7:0] pkt[$];
		logic [7:0] flip;
		int unsigned bad_pos, n;
		bad_pos = $urandom_range(7);
		flip = 8'd1 << $urandom_range(7);
		for (int i = 0; i < 8; i++)
			pkt.push_back(ART_ID[63 - 8*i -: 8] ^ ((bad_id && i == bad_pos) ? flip : 8'd0));
		pkt.push_back(op[7:0]);
		pkt.push_back(op[15:8]);
		pkt.push_back(ver[15:8]);
		pkt.push_back(ver[7:0]);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(uni[7:0]);
		pkt.push_back({1'($urandom), uni[14:8]});
		pkt.push_back(count[15:8]);
		pkt.push_back(count[7:0]);
		for (int unsigned i = 0; i < body; i++) pkt.push_back(pick_slot(fill));
		n = (cut != 0 && cut < pkt.size()) ? cut : pkt.size();
		for (int unsigned i = 0; i < n; i++) tx_bytes.push_back('{pkt[i], i == n - 1, 1'b0});
	endtask

	task automatic push_noise(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			tx_bytes.push_back('{8'($urandom), i == len - 1, 1'b0});
	endtask

	// Mostly well-formed packets for the current filter, plus each kind of defect.
	task automatic push_random_dgram();
		int unsigned kind, body, cut;
		logic [15:0] op, ver, count;
		logic [14:0] uni;
		bit bad_id;
		kind = $urandom_range(99);
		if (kind >= 93) begin
			push_noise($urandom_range(1, 20));
			return;
		end
		op = acd_pkg::OP_DMX;
		ver = $urandom_range(1) ? acd_pkg::MIN_VERSION : 16'($urandom_range(14, 65535));
		uni = cfg.universe_filter;
		bad_id = 1'b0;
		cut = 0;
		count = ($urandom_range(15) == 0) ? 16'($urandom_range(2, 40)) :
			16'($urandom_range(2, 8));
		body = ($urandom_range(9) == 0) ? count + $urandom_range(1, 6) : count;
		if (kind >= 87) begin
			uni = 15'($urandom);
		end else if (kind >= 82) begin
			body = $urandom_range(count - 1);
		end else if (kind >= 78) begin
			case ($urandom_range(2))
				0: count = 16'd0;
				1: count = 16'd1;
				default: count = 16'($urandom_range(513, 65535));
			endcase
			body = $urandom_range(8);
		end else if (kind >= 74) begin
			ver = 16'($urandom_range(13));
		end else if (kind >= 70) begin
			op = 16'($urandom);
		end else if (kind >= 65) begin
			bad_id = 1'b1;
		end else if (kind >= 60) begin
			cut = $urandom_range(1, 17);
		end
		push_dgram(op, ver, uni, count, body, cut, bad_id, -1);
	endtask

	// One register write transaction; the mirrored configuration follows it.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			acd_pkg::REG_UNIVERSE_FILTER: cfg.universe_filter = val[14:0];
			acd_pkg::REG_START_SLOT:      cfg.start_slot = val[9:0];
			acd_pkg::REG_FREQ_MIN:        cfg.freq_min = val[7:0];
			acd_pkg::REG_FREQ_MAX:        cfg.freq_max = val[7:0];
			acd_pkg::REG_AMP_MAX:         cfg.amp_max = val[14:0];
			acd_pkg::REG_MORPH_MAX:       cfg.morph_max = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until everything is sent and every result is back, then lets the block settle.
	task automatic drain();
		while (tx_bytes.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Every accepted input transaction is run through the mirrored decoder.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			decode_byte(data_byte, last_byte);
			byte_taken = 1'b1;
		end
	end

	// Input driver: presents the next queued byte or idles at random.
	always @(negedge clk) begin
		payload_byte_t nxt;
		if (arst_n && (!in_valid || byte_taken)) begin
			byte_taken = 1'b0;
			if (tx_bytes.size() != 0 && tx_bytes[0].pause && pending_results.size() == 0)
				tx_bytes.delete(0);
			if (tx_bytes.size() != 0 && !tx_bytes[0].pause &&
					$urandom_range(99) >= snd_idle_pct) begin
				nxt = tx_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data;
				last_byte <= nxt.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result ready: random stalls, or a long hold-off on request.
	always @(negedge clk) begin
		if (rcv_hold_req) begin
			rcv_hold_req = 1'b0;
			rcv_hold_left = HOLD_CYCLES;
		end
		if (rcv_hold_left != 0) begin
			rcv_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Result monitor: each output transaction against the oldest expectation.
	always @(posedge clk) begin
		dmx_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation pending: status %0d", status);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("packet_universe", want.universe, packet_universe);
				check_field("mode", want.ctl.mode, mode);
				check_field("freq_x", want.ctl.freq_x, freq_x);
				check_field("freq_y", want.ctl.freq_y, freq_y);
				check_field("amplitude", want.ctl.amplitude, amplitude);
				check_field("hue", want.ctl.hue, hue);
				check_field("intensity", want.ctl.intensity, intensity);
				check_field("morph_speed", want.ctl.morph, morph_speed);
				check_field("phase_offset", want.ctl.phase, phase_offset);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed datagrams under the reset configuration.
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd8, 8, 0, 1'b0, 255);
		push_dgram(acd_pkg::OP_DMX, 16'hFFFF, 15'd0, 16'd8, 8, 0, 1'b0, 0);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd3, 10, 0, 1'b0, 255);
		push_noise(1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd8, 8, 17, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd8, 0, 0, 1'b1, -1);
		push_dgram(16'h0050, acd_pkg::MIN_VERSION, 15'd0, 16'd8, 0, 0, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, 16'd13, 15'd0, 16'd8, 0, 0, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd1, 0, 0, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd513, 0, 0, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'd0, 16'd10, 9, 0, 1'b0, -1);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, 15'h7FFF, 16'd8, 8, 0, 1'b0, -1);
		repeat (2) push_random_dgram();
		drain();

		// Start slot zero, negative frequency span, largest scales; sender idles.
		snd_idle_pct = 46;
		write_reg(acd_pkg::REG_UNIVERSE_FILTER, 16'($urandom_range(1, 32766)));
		write_reg(acd_pkg::REG_START_SLOT, 16'd0);
		write_reg(acd_pkg::REG_FREQ_MIN, 16'hABFF);
		write_reg(acd_pkg::REG_FREQ_MAX, 16'd0);
		write_reg(acd_pkg::REG_AMP_MAX, 16'h7FFF);
		write_reg(acd_pkg::REG_MORPH_MAX, 16'hFFFF);
		write_reg(REG_UNUSED, 16'($urandom));
		repeat (3) push_random_dgram();
		drain();

		// Upper write bits dropped, full frequency span, zero scales; receiver stalls.
		snd_idle_pct = 0;
		rcv_stall_pct = 46;
		write_reg(acd_pkg::REG_UNIVERSE_FILTER, 16'hFFFF);
		write_reg(acd_pkg::REG_START_SLOT, 16'hFC04);
		write_reg(acd_pkg::REG_FREQ_MIN, 16'd0);
		write_reg(acd_pkg::REG_FREQ_MAX, 16'd255);
		write_reg(acd_pkg::REG_AMP_MAX, 16'd0);
		write_reg(acd_pkg::REG_MORPH_MAX, 16'd0);
		push_dgram(acd_pkg::OP_DMX, acd_pkg::MIN_VERSION, cfg.universe_filter, 16'd12, 12, 0,
			1'b0, -1);
		repeat (3) push_random_dgram();
		drain();

		// Random settings with both sides idling.
		snd_idle_pct = 28;
		rcv_stall_pct = 28;
		write_reg(acd_pkg::REG_UNIVERSE_FILTER, 16'($urandom));
		write_reg(acd_pkg::REG_START_SLOT, 16'($urandom_range(1, 12)));
		write_reg(acd_pkg::REG_FREQ_MIN, 16'($urandom));
		write_reg(acd_pkg::REG_FREQ_MAX, 16'($urandom));
		write_reg(acd_pkg::REG_AMP_MAX, 16'($urandom));
		write_reg(acd_pkg::REG_MORPH_MAX, 16'($urandom));
		repeat (3) push_random_dgram();
		drain();

		// Back pressure: the receiver holds off while the sender keeps offering,
		// then the sender waits for every result before going on.
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		write_reg(acd_pkg::REG_START_SLOT, 16'($urandom_range(1, 12)));
		write_reg(acd_pkg::REG_FREQ_MIN, 16'($urandom));
		write_reg(acd_pkg::REG_AMP_MAX, 16'($urandom));
		rcv_hold_req = 1'b1;
		repeat (6) push_noise(1);
		repeat (2) push_random_dgram();
		tx_bytes.push_back('{8'd0, 1'b0, 1'b1});
		repeat (2) push_random_dgram();
		drain();

		// Start slot far beyond any frame: all control slots read as zero.
		write_reg(acd_pkg::REG_START_SLOT, 16'hFFFF);
		repeat (2) push_random_dgram();
		drain();

		if (!failed && pending_results.size() == 0)
			$display("artdmx_control_channel_decoder_test passed");
		else
			$display("artdmx_control_channel_decoder_test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("artdmx_control_channel_decoder_test failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/acd_pkg.sv
rtl/core/acd_parser.sv
rtl/core/acd_scaler.sv
rtl/core/artdmx_control_channel_decoder.sv
tb/artdmx_control_channel_decoder_test.sv
